FILE: rtl/ptlg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptlg_pkg: per-thread Lehmer generator shared definitions
// Item kinds, pipeline control word and the fixed arithmetic constants of
// the perturbation offset and the Park-Miller step.
// ----------------------------------------------------------------------------
package ptlg_pkg;

	typedef enum logic {
		KIND_SEED = 1'b0,
		KIND_GEN  = 1'b1
	} kind_t;

	typedef struct packed {
		logic  valid;
		kind_t kind;
	} ctl_t;

	// Park-Miller multiplier and Mersenne modulus 2^31-1
	localparam logic [14:0] LEHMER_MULT = 15'd16807;
	localparam logic [30:0] LEHMER_MOD  = 31'h7FFFFFFF;

	// p / 1000 as (p * ceil(2^35/1000)) >> 35, exact for p < 2^25
	localparam logic [25:0] RECIP_P = 26'd34359739;
	localparam logic [9:0]  DIV_K   = 10'd1000;
	// v / 1000 as (v * ceil(2^30/1000)) >> 30, exact for v < 2^20
	localparam logic [20:0] RECIP_V = 21'd1073742;
	// 2^40 = 1000 * DIV_Q + REM_R
	localparam logic [30:0] DIV_Q   = 31'd1099511627;
	localparam logic [9:0]  REM_R   = 10'd776;
	// ceil(p / 2^24) = (p + 2^24 - 1) >> 24
	localparam logic [24:0] C_ROUND = 25'h0FFFFFF;

endpackage
`default_nettype wire

FILE: rtl/ptlg_offset.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptlg_offset: perturbation offset pipeline
// Two stages that turn the Q1.24 value p into
// floor(p * (2^64-1) / (1000 * 2^24)) = (a << 40) + b*DIV_Q + floor((776b - c)/1000)
// with a = p / 1000, b = p % 1000, c = ceil(p / 2^24).
// ----------------------------------------------------------------------------
module ptlg_offset (
	input  wire logic        clk,
	input  wire logic        adv,
	input  wire logic [24:0] perturbation_s1,
	output logic      [63:0] offset_s3
);

	logic [50:0] a_prod;
	logic [15:0] a_c;
	logic [24:0] a_k;
	logic [9:0]  b_c;
	logic [25:0] c_sum;

	logic [15:0] a_s2;
	logic [9:0]  b_s2;
	logic [1:0]  c_s2;

	logic [19:0] v_pos;
	logic        v_neg;
	logic [19:0] v_c;
	logic [40:0] d_prod;
	logic [40:0] bq;
	logic [63:0] off_c;

	// split p into quotient and remainder by 1000
	assign a_prod = 51'(perturbation_s1) * 51'(ptlg_pkg::RECIP_P);
	assign a_c    = a_prod[50:35];
	assign a_k    = 25'(a_c) * 25'(ptlg_pkg::DIV_K);
	assign b_c    = 10'(perturbation_s1 - a_k);
	assign c_sum  = 26'(perturbation_s1) + 26'(ptlg_pkg::C_ROUND);

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2 <= a_c;
			b_s2 <= b_c;
			c_s2 <= c_sum[25:24];
		end
	end

	// negative only for b == 0 with p > 0: the fraction term is then -1
	assign v_pos  = 20'(b_s2) * 20'(ptlg_pkg::REM_R);
	assign v_neg  = v_pos < 20'(c_s2);
	assign v_c    = v_pos - 20'(c_s2);
	assign d_prod = 41'(v_c) * 41'(ptlg_pkg::RECIP_V);
	assign bq     = 41'(b_s2) * 41'(ptlg_pkg::DIV_Q);
	assign off_c  = {8'b0, a_s2, 40'b0} + 64'(bq) + (v_neg ? '1 : 64'(d_prod[39:30]));

	always_ff @(posedge clk) begin
		if (adv) begin
			offset_s3 <= off_c;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/ptlg_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptlg_bank: thread state memory and Lehmer step
// Registered read of the selected slot with write bypass, then offset add,
// multiply by 16807 modulo 2^64 and Mersenne fold modulo 2^31-1; write back.
// ----------------------------------------------------------------------------
module ptlg_bank #(
	parameter int THREAD_COUNT = 8,
	parameter int SLOT_W       = 3
) (
	input  wire logic                  clk,
	input  wire logic                  adv,
	input  wire logic [SLOT_W-1:0]     rd_slot_s2,
	input  wire ptlg_pkg::ctl_t        ctl_s3,
	input  wire logic [SLOT_W-1:0]     slot_s3,
	input  wire logic [63:0]           seed_s3,
	input  wire logic [63:0]           offset_s3,
	output logic      [30:0]           new_state,
	output logic      [23:0]           unit_fraction
);

	logic [63:0] mem_q [THREAD_COUNT];
	logic [63:0] state_s3;

	logic [63:0] sum_c;
	logic [63:0] prod_c;
	logic [33:0] fold1_c;
	logic [31:0] fold2_c;
	logic [30:0] lehmer_c;
	logic [63:0] wr_data;
	logic        wr_en;

	assign sum_c   = state_s3 + offset_s3;
	assign prod_c  = sum_c * 64'(ptlg_pkg::LEHMER_MULT);
	// 2^31 == 1 modulo 2^31-1: fold the high part onto the low part twice
	assign fold1_c = 34'(prod_c[63:31]) + 34'(prod_c[30:0]);
	assign fold2_c = 32'(fold1_c[33:31]) + 32'(fold1_c[30:0]);
	assign lehmer_c = (fold2_c >= 32'(ptlg_pkg::LEHMER_MOD))
		? 31'(fold2_c - 32'(ptlg_pkg::LEHMER_MOD)) : fold2_c[30:0];

	assign wr_en   = adv && ctl_s3.valid;
	assign wr_data = (ctl_s3.kind == ptlg_pkg::KIND_SEED) ? seed_s3 : {33'b0, lehmer_c};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[slot_s3] <= wr_data;
		end
	end

	// forward a write landing on the slot being read in the same cycle
	always_ff @(posedge clk) begin
		if (adv) begin
			if (wr_en && (slot_s3 == rd_slot_s2)) begin
				state_s3 <= wr_data;
			end else begin
				state_s3 <= mem_q[rd_slot_s2];
			end
		end
	end

	// floor(s * 2^24 / (2^31-1)) equals s >> 7 for every s below the modulus
	assign new_state     = lehmer_c;
	assign unit_fraction = lehmer_c[30:7];

endmodule
`default_nettype wire

FILE: rtl/per_thread_lehmer_generator_core.sv
`default_nettype none
// A generate item passes the s1, s2 and s3 stage registers, then the output register.
// Throughput: one item per cycle; in_ready drops only while a result waits
// in the output register and out_ready is low.
// Reset clears the pipeline valid bits, the output valid and multi-thread
// mode; the thread state bank is not cleared and holds junk until seeded.
// ----------------------------------------------------------------------------
// per_thread_lehmer_generator_core: bank of per-thread Lehmer generators
// Seed items load a slot, generate items perturb, step and store a slot and
// return the new state and its Q0.24 fraction.
// ----------------------------------------------------------------------------
module per_thread_lehmer_generator_core #(
	parameter int THREAD_COUNT = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        multi_thread_mode_we,
	input  wire logic        multi_thread_mode,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [2:0]  thread_slot,
	input  wire logic [63:0] seed_value,
	input  wire logic [24:0] perturbation,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [30:0] new_state,
	output logic      [23:0] unit_fraction
);

	localparam int SLOT_W = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;

	logic                 mode_q;
	logic                 adv;
	logic [SLOT_W-1:0]    slot_map [8];
	logic [SLOT_W-1:0]    sel_slot;

	ptlg_pkg::ctl_t       ctl_s1, ctl_s2, ctl_s3;
	logic [SLOT_W-1:0]    slot_s1, slot_s2, slot_s3;
	logic [63:0]          seed_s1, seed_s2, seed_s3;
	logic [24:0]          pert_s1;
	logic [63:0]          offset_s3;

	logic                 out_valid_q;
	logic [30:0]          new_state_q;
	logic [23:0]          unit_fraction_q;
	logic [30:0]          step_state;
	logic [23:0]          step_fraction;

	// slot numbers past the bank wrap around
	for (genvar i = 0; i < 8; i++) begin : g_slot_map
		assign slot_map[i] = SLOT_W'(i % THREAD_COUNT);
	end

	assign sel_slot = mode_q ? slot_map[thread_slot] : '0;

	// advance everything unless a result is held up at the output
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (multi_thread_mode_we) begin
			mode_q <= multi_thread_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			ctl_s3      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			ctl_s1      <= '{valid: in_valid, kind: ptlg_pkg::kind_t'(kind)};
			ctl_s2      <= ctl_s1;
			ctl_s3      <= ctl_s2;
			out_valid_q <= ctl_s3.valid && (ctl_s3.kind == ptlg_pkg::KIND_GEN);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slot_s1         <= sel_slot;
			seed_s1         <= seed_value;
			pert_s1         <= perturbation;
			slot_s2         <= slot_s1;
			seed_s2         <= seed_s1;
			slot_s3         <= slot_s2;
			seed_s3         <= seed_s2;
			new_state_q     <= step_state;
			unit_fraction_q <= step_fraction;
		end
	end

	ptlg_offset u_offset (
		.clk             (clk),
		.adv             (adv),
		.perturbation_s1 (pert_s1),
		.offset_s3       (offset_s3)
	);

	ptlg_bank #(
		.THREAD_COUNT (THREAD_COUNT),
		.SLOT_W       (SLOT_W)
	) u_bank (
		.clk           (clk),
		.adv           (adv),
		.rd_slot_s2    (slot_s2),
		.ctl_s3        (ctl_s3),
		.slot_s3       (slot_s3),
		.seed_s3       (seed_s3),
		.offset_s3     (offset_s3),
		.new_state     (step_state),
		.unit_fraction (step_fraction)
	);

	assign out_valid     = out_valid_q;
	assign new_state     = new_state_q;
	assign unit_fraction = unit_fraction_q;

endmodule
`default_nettype wire

FILE: rtl/ptlg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptlg_checker: port-level checks for the Lehmer generator bank
// Result range and fraction consistency, plus output hold under back-pressure.
// ----------------------------------------------------------------------------
module ptlg_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [30:0] new_state,
	input wire logic [23:0] unit_fraction
);

	// a reduced state never reaches the modulus
	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (new_state != ptlg_pkg::LEHMER_MOD))
		else $error("new_state equals the modulus");

	// fraction must track the state it came from
	a_fraction: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (unit_fraction == new_state[30:7]))
		else $error("unit_fraction does not match new_state");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(new_state)
			&& $stable(unit_fraction)))
		else $error("stalled result changed or dropped");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result withdrawn without transfer");

endmodule

bind per_thread_lehmer_generator_core ptlg_checker u_ptlg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.new_state     (new_state),
	.unit_fraction (unit_fraction)
);
`default_nettype wire
